>>> rtl/morse_key_timing_packetizer_defines.svh
// Assertion macros for the key timing packetizer.
// Taken in by every RTL file that carries concurrent assertions.
`ifndef MORSE_KEY_TIMING_PACKETIZER_DEFINES_SVH
`define MORSE_KEY_TIMING_PACKETIZER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define MKTP_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define MKTP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/mktp_pkg.sv
// Shared types and constants of the key timing packetizer.
// No dependencies; every other RTL file but mktp_ram and the macro header imports it.
package mktp_pkg;

   localparam int unsigned MAX_ELEMENTS_DEF = 51;
   localparam int unsigned TIMER_W          = 16;
   localparam int unsigned COUNT_W          = 6;
   localparam int unsigned DUR_W            = 17;
   localparam int unsigned SEQ_W            = 32;
   localparam int unsigned CSR_INDEX_W      = 8;
   localparam int unsigned CSR_DATA_W       = 16;

   localparam logic [TIMER_W-1:0] TIMER_MAX        = '1;
   localparam logic [DUR_W-1:0]   LEAD_SPACE_MS    = 17'h1F830;  // -2000
   localparam logic [TIMER_W-1:0] KEYUP_TO_RESET   = 16'd250;
   localparam logic [TIMER_W-1:0] SESSION_TO_RESET = 16'd5000;

   // Register indexes of the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_KEYUP_TIMEOUT   = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SESSION_TIMEOUT = 8'd1;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_FLUSH = 2'b10
   } mktp_state_type;

   // Controller to datapath
   typedef struct packed {
      logic tick;      // accept one key tick
      logic rd_issue;  // read next held element
      logic move;      // load read element into the output register
   } mktp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic flush;     // current tick completes a packet
      logic rd_more;   // packet elements still to read
   } mktp_sts_type;

endpackage

>>> rtl/mktp_if.sv
// Channel interfaces: key tick input, duration output, register writes.
// Depends on mktp_pkg.
interface mktp_req_if import mktp_pkg::*; ();
   logic valid;
   logic ready;
   logic key_down;

   modport source (output valid, output key_down, input ready);
   modport sink   (input valid, input key_down, output ready);
endinterface

interface mktp_rsp_if import mktp_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [SEQ_W-1:0]        packet_sequence;
   logic [COUNT_W-1:0]      element_index;
   logic signed [DUR_W-1:0] duration_ms;
   logic                    last_element;

   modport source (output valid, output packet_sequence, output element_index,
                   output duration_ms, output last_element, input ready);
   modport sink   (input valid, input packet_sequence, input element_index,
                   input duration_ms, input last_element, output ready);
endinterface

interface mktp_csr_if import mktp_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/morse_key_timing_packetizer.sv
// Top level of the key timing packetizer.
// Depends on mktp_pkg, the channel interfaces, mktp_ctrl and mktp_dp.
//
// Usage:
//   req_ch carries one key level per millisecond tick (key_down, 1 = pressed).
//   rsp_ch returns the durations of a packet, one transaction per element:
//   sequence number, index in the packet, signed duration in ms (mark > 0,
//   space < 0) and a last mark on the final element.
//   csr_ch writes the key-up timeout (index 0) and the session timeout
//   (index 1); writes are taken at any cycle and should happen while idle.
// Timing:
//   A tick that completes no packet leaves req_ch ready, and the next tick can
//   follow at once. A tick that completes a packet holds req_ch until each of its
//   elements has left the RAM read register: the element store has one read port
//   and the read sequencer fetches one element a cycle while rsp_ch does not stall.
//   The first element passes the RAM read register and then the output register.
// Reset clears the session, counters and timeouts (250 ms and 5000 ms).
// If rsp_ch stalls, the output register and the RAM read register hold and
// element reads pause; no element is lost.
module morse_key_timing_packetizer import mktp_pkg::*; #(
   parameter int unsigned MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
   input logic clock,
   input logic reset,
   mktp_req_if.sink   req_ch,
   mktp_rsp_if.source rsp_ch,
   mktp_csr_if.sink   csr_ch
);

   mktp_cmd_type cmd;
   mktp_sts_type sts;

   assign csr_ch.ready = 1'b1;

   mktp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   mktp_dp #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .key_down        (req_ch.key_down),
      .csr_wr          (csr_ch.valid),
      .csr_index       (csr_ch.index),
      .csr_data        (csr_ch.data),
      .packet_sequence (rsp_ch.packet_sequence),
      .element_index   (rsp_ch.element_index),
      .duration_ms     (rsp_ch.duration_ms),
      .last_element    (rsp_ch.last_element)
   );

endmodule

>>> rtl/mktp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mktp_ram #(
   parameter int unsigned WIDTH = 17,
   parameter int unsigned DEPTH = 51
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/mktp_ctrl.sv
// Controller: tick handshake, packet read sequencing and output register valid.
// Depends on mktp_pkg and the assertion macro header.
`include "morse_key_timing_packetizer_defines.svh"

module mktp_ctrl import mktp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output mktp_cmd_type cmd,
   input  mktp_sts_type sts
);

   mktp_state_type state_ff, state_in;
   logic           pend_vld_ff, pend_vld_in;
   logic           out_vld_ff, out_vld_in;
   logic           accept;
   logic           move;
   logic           issue;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;

   // Advance read pipeline: RAM data register, then output register
   assign move  = pend_vld_ff & (~out_vld_ff | rsp_ready);
   assign issue = (state_ff == ST_FLUSH) & sts.rd_more & (~pend_vld_ff | move);

   assign pend_vld_in = issue | (pend_vld_ff & ~move);
   assign out_vld_in  = move | (out_vld_ff & ~rsp_ready);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && sts.flush) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (!sts.rd_more && !pend_vld_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         pend_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         pend_vld_ff <= pend_vld_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   assign cmd.tick     = accept;
   assign cmd.rd_issue = issue;
   assign cmd.move     = move;
   assign rsp_valid    = out_vld_ff;

   `MKTP_ASSERT_IMPL(a_idle_pipe_empty, clock, reset, state_ff == ST_IDLE, !pend_vld_ff, "read pending while idle")
   `MKTP_ASSERT_NEXT(a_move_fills_out, clock, reset, move, out_vld_ff, "moved element not presented")
   `MKTP_ASSERT_NEXT(a_flush_done_idle, clock, reset, (state_ff == ST_FLUSH) && !sts.rd_more && !pend_vld_ff, state_ff == ST_IDLE, "flush did not end")

endmodule

>>> rtl/mktp_dp.sv
// Datapath: phase timing, element store, sequence counter, configuration
// registers and output payload. Depends on mktp_pkg, mktp_ram and the macro header.
`include "morse_key_timing_packetizer_defines.svh"

module mktp_dp import mktp_pkg::*; #(
   parameter int unsigned MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  mktp_cmd_type            cmd,
   output mktp_sts_type            sts,
   input  logic                    key_down,
   input  logic                    csr_wr,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data,
   output logic [SEQ_W-1:0]        packet_sequence,
   output logic [COUNT_W-1:0]      element_index,
   output logic signed [DUR_W-1:0] duration_ms,
   output logic                    last_element
);

   localparam int unsigned AW = $clog2(MAX_ELEMENTS);
   localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_ELEMENTS);

   logic                 session_ff, session_in;
   logic                 phase_ff, phase_in;
   logic [TIMER_W-1:0]   gap_ff, gap_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [SEQ_W-1:0]     seq_ff, seq_in;
   logic [TIMER_W-1:0]   keyup_to_ff, sess_to_ff;
   logic [COUNT_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0]   len_ff, len_in;
   logic [COUNT_W-1:0]   pend_idx_ff;
   logic [SEQ_W-1:0]     out_seq_ff;
   logic [COUNT_W-1:0]   out_idx_ff;
   logic [DUR_W-1:0]     out_dur_ff;
   logic                 out_last_ff;

   logic                 same;
   logic [TIMER_W-1:0]   gap_nx;
   logic                 store;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [DUR_W-1:0]     wr_data;
   logic [COUNT_W-1:0]   cnt_nx;
   logic                 flush;
   logic [DUR_W-1:0]     rd_data;

   // Phase tracking for one tick inside a session
   assign same   = (key_down == phase_ff);
   assign gap_nx = same ? ((gap_ff == TIMER_MAX) ? gap_ff : gap_ff + 1'b1)
                        : TIMER_W'(1);
   assign store  = ~same & (count_ff < MAX_CNT);
   assign cnt_nx = count_ff + COUNT_W'(store);
   assign flush  = (cnt_nx >= MAX_CNT)
                 | (~key_down & (gap_nx > keyup_to_ff) & (cnt_nx > COUNT_W'(1)));

   // Store lead space at entry zero on session start, else the ending phase's length
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = count_ff[AW-1:0];
      wr_data = LEAD_SPACE_MS;
      if (cmd.tick) begin
         if (!session_ff) begin
            wr_en   = key_down;
            wr_addr = '0;
         end else begin
            wr_en   = store;
            wr_data = phase_ff ? {1'b0, gap_ff} : (~{1'b0, gap_ff} + 1'b1);
         end
      end
   end

   // Tick update of session state
   always_comb begin
      session_in = session_ff;
      phase_in   = phase_ff;
      gap_in     = gap_ff;
      count_in   = count_ff;
      seq_in     = seq_ff;
      len_in     = len_ff;
      rd_ptr_in  = rd_ptr_ff + COUNT_W'(cmd.rd_issue);
      if (cmd.tick) begin
         if (!session_ff) begin
            if (key_down) begin
               session_in = 1'b1;
               phase_in   = 1'b1;
               gap_in     = TIMER_W'(1);
               count_in   = COUNT_W'(1);
            end
         end else begin
            phase_in = key_down;
            gap_in   = gap_nx;
            count_in = cnt_nx;
            if (flush) begin
               count_in  = '0;
               seq_in    = seq_ff + 1'b1;
               len_in    = cnt_nx;
               rd_ptr_in = '0;
            end
            if (!key_down && (gap_nx > sess_to_ff)) begin
               session_in = 1'b0;
            end
         end
      end
   end

   assign sts.flush   = session_ff & flush;
   assign sts.rd_more = (rd_ptr_ff != len_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         session_ff  <= 1'b0;
         phase_ff    <= 1'b0;
         gap_ff      <= '0;
         count_ff    <= '0;
         seq_ff      <= '0;
         len_ff      <= '0;
         rd_ptr_ff   <= '0;
         keyup_to_ff <= KEYUP_TO_RESET;
         sess_to_ff  <= SESSION_TO_RESET;
      end else begin
         session_ff <= session_in;
         phase_ff   <= phase_in;
         gap_ff     <= gap_in;
         count_ff   <= count_in;
         seq_ff     <= seq_in;
         len_ff     <= len_in;
         rd_ptr_ff  <= rd_ptr_in;
         if (csr_wr && (csr_index == CSR_KEYUP_TIMEOUT)) begin
            keyup_to_ff <= csr_data;
         end
         if (csr_wr && (csr_index == CSR_SESSION_TIMEOUT)) begin
            sess_to_ff <= csr_data;
         end
      end
   end

   // Element store
   mktp_ram #(
      .WIDTH (DUR_W),
      .DEPTH (MAX_ELEMENTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_issue),
      .rd_addr (rd_ptr_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   // Track index of the element in the RAM read register, load output payload
   always_ff @(posedge clock) begin
      if (cmd.rd_issue) begin
         pend_idx_ff <= rd_ptr_ff;
      end
      if (cmd.move) begin
         out_seq_ff  <= seq_ff;
         out_idx_ff  <= pend_idx_ff;
         out_dur_ff  <= rd_data;
         out_last_ff <= (pend_idx_ff == len_ff - 1'b1);
      end
   end

   assign packet_sequence = out_seq_ff;
   assign element_index   = out_idx_ff;
   assign duration_ms     = $signed(out_dur_ff);
   assign last_element    = out_last_ff;

   `MKTP_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= MAX_CNT, "element count past capacity")
   `MKTP_ASSERT_IMPL(a_rd_ptr_bound, clock, reset, 1'b1, rd_ptr_ff <= len_ff, "read pointer past packet length")
   `MKTP_ASSERT_IMPL(a_idle_key_up, clock, reset, !session_ff, !phase_ff, "key phase down outside a session")

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the key timing packetizer: drives key ticks, timeouts
// and output stalls, and checks every emitted duration against its own predictor.
// Depends on mktp_pkg, the channel interfaces and the packetizer RTL.
module tb;
   import mktp_pkg::*;

   localparam int unsigned SETTLE_CYCLES = 64;
   localparam int unsigned CYCLE_LIMIT   = 1_500_000;

   typedef struct {
      logic [SEQ_W-1:0]        seq;
      logic [COUNT_W-1:0]      index;
      logic signed [DUR_W-1:0] dur;
      logic                    last;
   } duration_rec_type;

   logic clock;
   logic reset;

   mktp_req_if req_ch ();
   mktp_rsp_if rsp_ch ();
   mktp_csr_if csr_ch ();

   morse_key_timing_packetizer DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Predictor state: a copy of the session, timer, held elements and timeouts
   logic                    sess_open;
   logic                    phase_down;
   logic [TIMER_W-1:0]      phase_ms;
   int unsigned             held_count;
   logic signed [DUR_W-1:0] held_ms [MAX_ELEMENTS_DEF];
   logic [SEQ_W-1:0]        packet_seq;
   logic [TIMER_W-1:0]      keyup_limit;
   logic [TIMER_W-1:0]      session_limit;

   duration_rec_type pending_durations [$];
   int unsigned      error_count = 0;
   int unsigned      ticks_sent  = 0;
   bit               pace_on     = 1'b1;
   bit               stall_on    = 1'b1;

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: end the run if it hangs
   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("%0t: cycle limit reached, %0d durations still pending", $realtime,
               pending_durations.size());
      $display("morse_key_timing_packetizer test failed");
      $finish;
   end

   // Predictor
   function automatic void hold_element(input logic signed [DUR_W-1:0] dur);
      if (held_count < MAX_ELEMENTS_DEF) begin
         held_ms[held_count] = dur;
         held_count++;
      end
   endfunction

   function automatic void emit_packet();
      duration_rec_type rec;
      packet_seq = packet_seq + 1'b1;
      for (int unsigned i = 0; i < held_count; i++) begin
         rec.seq   = packet_seq;
         rec.index = i[COUNT_W-1:0];
         rec.dur   = held_ms[i];
         rec.last  = (i + 1 == held_count);
         pending_durations.push_back(rec);
      end
      held_count = 0;
   endfunction

   function automatic void predict_tick(input logic key);
      logic signed [DUR_W-1:0] dur;
      if (!sess_open) begin
         // Idle: a press opens the session with the lead space
         if (!key) return;
         sess_open  = 1'b1;
         phase_down = 1'b1;
         phase_ms   = TIMER_W'(1);
         held_count = 0;
         hold_element(LEAD_SPACE_MS);
         return;
      end
      if (key == phase_down) begin
         if (phase_ms != TIMER_MAX) phase_ms++;
      end else begin
         dur = {1'b0, phase_ms};
         if (!phase_down) dur = -dur;
         hold_element(dur);
         phase_down = key;
         phase_ms   = TIMER_W'(1);
      end
      if (held_count >= MAX_ELEMENTS_DEF)
         emit_packet();
      else if (!phase_down && phase_ms > keyup_limit && held_count > 1)
         emit_packet();
      if (!phase_down && phase_ms > session_limit) sess_open = 1'b0;
   endfunction

   // Output ready: a random stall, when stalls are on, before each transaction
   initial begin : rsp_ready_driver
      int unsigned stall;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         stall = stall_on ? $urandom_range(0, 7) : 0;
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
      end
   end

   // Compare each output transaction with the oldest predicted duration
   always @(posedge clock) begin : duration_checker
      duration_rec_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_durations.size() == 0) begin
            error_count++;
            $display("%0t: unexpected duration, expected none, actual seq %0d index %0d dur %0d last %0b",
                     $realtime, rsp_ch.packet_sequence, rsp_ch.element_index,
                     rsp_ch.duration_ms, rsp_ch.last_element);
         end else begin
            want = pending_durations.pop_front();
            if (rsp_ch.packet_sequence !== want.seq) begin
               error_count++;
               $display("%0t: packet_sequence expected %0d actual %0d", $realtime,
                        want.seq, rsp_ch.packet_sequence);
            end
            if (rsp_ch.element_index !== want.index) begin
               error_count++;
               $display("%0t: element_index expected %0d actual %0d", $realtime,
                        want.index, rsp_ch.element_index);
            end
            if (rsp_ch.duration_ms !== want.dur) begin
               error_count++;
               $display("%0t: duration_ms expected %0d actual %0d", $realtime,
                        want.dur, rsp_ch.duration_ms);
            end
            if (rsp_ch.last_element !== want.last) begin
               error_count++;
               $display("%0t: last_element expected %0b actual %0b", $realtime,
                        want.last, rsp_ch.last_element);
            end
         end
      end
   end

   // Send one key tick, optionally after an idle gap
   task automatic send_tick(input logic key);
      int unsigned gap;
      gap = pace_on ? $urandom_range(0, 7) : 0;
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.key_down <= key;
      do @(posedge clock); while (!req_ch.ready);
      ticks_sent++;
      predict_tick(key);
   endtask

   task automatic send_run(input logic key, input int unsigned count);
      for (int unsigned i = 0; i < count; i++) send_tick(key);
   endtask

   // Hold the sender until every predicted duration has arrived, then settle
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (pending_durations.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write both timeouts (and optionally an unused index) while idle
   task automatic program_timeouts(input logic [CSR_DATA_W-1:0] keyup_ms,
                                   input logic [CSR_DATA_W-1:0] session_ms,
                                   input bit with_spare);
      logic [CSR_INDEX_W-1:0] idx_list [$];
      logic [CSR_DATA_W-1:0]  data_list [$];
      drain_results();
      idx_list.push_back(CSR_KEYUP_TIMEOUT);
      data_list.push_back(keyup_ms);
      idx_list.push_back(CSR_SESSION_TIMEOUT);
      data_list.push_back(session_ms);
      if (with_spare) begin
         idx_list.push_back(CSR_INDEX_W'($urandom_range(CSR_SESSION_TIMEOUT + 1,
                                                         {CSR_INDEX_W{1'b1}})));
         data_list.push_back(CSR_DATA_W'($urandom_range(0, {CSR_DATA_W{1'b1}})));
      end
      csr_ch.valid <= 1'b1;
      foreach (idx_list[i]) begin
         csr_ch.index <= idx_list[i];
         csr_ch.data  <= data_list[i];
         do @(posedge clock); while (!csr_ch.ready);
         case (idx_list[i])
            CSR_KEYUP_TIMEOUT:   keyup_limit   = data_list[i];
            CSR_SESSION_TIMEOUT: session_limit = data_list[i];
            default: ;
         endcase
      end
      csr_ch.valid <= 1'b0;
   endtask

   // Reset timeouts: idle key-up ignored, one packet after 250 ms, end after 5000 ms
   task automatic test_reset_timeouts();
      pace_on = 1'b0;
      send_run(1'b0, 3);
      send_run(1'b1, 2);
      send_run(1'b0, 3);
      send_run(1'b1, 1);
      send_run(1'b0, 5002);
      pace_on = 1'b1;
      drain_results();
   endtask

   // Zero timeouts flush on release; session timeout below key-up timeout drops
   task automatic test_timeout_edges();
      program_timeouts(16'd0, 16'd0, 1'b0);
      send_run(1'b1, 1);
      send_run(1'b0, 1);
      send_run(1'b0, 2);
      send_run(1'b1, 3);
      send_run(1'b0, 1);
      program_timeouts(16'd2, 16'd1, 1'b0);
      send_run(1'b1, 2);
      send_run(1'b0, 3);
      send_run(1'b1, 1);
      send_run(1'b0, 4);
      program_timeouts(16'd1, 16'd3, 1'b1);
      send_run(1'b1, 2);
      send_run(1'b0, 1);
      send_run(1'b1, 1);
      send_run(1'b0, 4);
   endtask

   // Alternate the key every tick so the store fills on a key-down tick, then
   // on a key-up tick; a lone element held at session end is dropped
   task automatic test_store_full();
      logic lvl;
      program_timeouts(16'd100, 16'd120, 1'b0);
      send_run(1'b1, 1);
      lvl = 1'b1;
      for (int i = 0; i < MAX_ELEMENTS_DEF - 1; i++) begin
         lvl = ~lvl;
         send_tick(lvl);
      end
      send_run(1'b1, 3);
      send_run(1'b0, 125);
      send_run(1'b1, 2);
      lvl = 1'b1;
      for (int i = 0; i < 2 * MAX_ELEMENTS_DEF - 1; i++) begin
         lvl = ~lvl;
         send_tick(lvl);
      end
      send_run(1'b0, 125);
   endtask

   // Drive marks and spaces past the timer range to check saturation at 65535
   task automatic test_saturation();
      program_timeouts(TIMER_MAX, TIMER_MAX, 1'b0);
      pace_on = 1'b0;
      send_run(1'b1, int'(TIMER_MAX) + 5);
      send_run(1'b0, int'(TIMER_MAX) + 5);
      send_run(1'b1, 1);
      program_timeouts(16'd0, TIMER_MAX, 1'b0);
      send_run(1'b0, 1);
      program_timeouts(16'd0, 16'd0, 1'b0);
      send_run(1'b0, 1);
      pace_on = 1'b1;
   endtask

   // Random settings per round; mostly well-formed key sequences, some noise
   task automatic test_random_sessions();
      int unsigned base_ticks;
      int          keyup_ms;
      int          session_ms;
      int unsigned phases;
      int unsigned space_len;
      base_ticks = ticks_sent;
      while (ticks_sent - base_ticks < 150) begin
         case ($urandom_range(0, 5))
            0:       keyup_ms = 0;
            1:       keyup_ms = 1;
            5:       keyup_ms = int'(TIMER_MAX);
            default: keyup_ms = $urandom_range(2, 12);
         endcase
         case ($urandom_range(0, 5))
            0:       session_ms = 0;
            1:       session_ms = $urandom_range(0, 4);
            5:       session_ms = int'(TIMER_MAX);
            default: session_ms = keyup_ms + $urandom_range(1, 30);
         endcase
         if (session_ms > int'(TIMER_MAX)) session_ms = int'(TIMER_MAX);
         program_timeouts(keyup_ms[15:0], session_ms[15:0], $urandom_range(0, 2) == 0);
         pace_on  = ($urandom_range(0, 3) != 0);
         stall_on = ($urandom_range(0, 3) != 0);
         // Noise: random key levels
         if ($urandom_range(0, 3) == 0)
            for (int i = 0; i < 24; i++) send_tick(1'($urandom_range(0, 1)));
         phases = $urandom_range(4, 12);
         for (int unsigned p = 0; p < phases; p++) begin
            send_run(1'b1, $urandom_range(1, 6));
            if ($urandom_range(0, 9) < 7)
               space_len = $urandom_range(1, (keyup_ms < 8) ? keyup_ms + 1 : 8);
            else
               space_len = ((keyup_ms < 60) ? keyup_ms : 60) + $urandom_range(1, 3);
            send_run(1'b0, space_len);
         end
         // Closing gap to end the session where the timeout is short enough
         send_run(1'b0, ((session_ms < 80) ? session_ms : 80) + 1);
      end
      pace_on  = 1'b1;
      stall_on = 1'b1;
   endtask

   // Main sequence
   initial begin
      reset           <= 1'b1;
      req_ch.valid    <= 1'b0;
      req_ch.key_down <= 1'b0;
      csr_ch.valid    <= 1'b0;
      csr_ch.index    <= CSR_KEYUP_TIMEOUT;
      csr_ch.data     <= '0;
      sess_open     = 1'b0;
      phase_down    = 1'b0;
      phase_ms      = '0;
      held_count    = 0;
      packet_seq    = '0;
      keyup_limit   = KEYUP_TO_RESET;
      session_limit = SESSION_TO_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_timeouts();
      test_timeout_edges();
      test_store_full();
      test_saturation();
      test_random_sessions();

      drain_results();
      if (error_count == 0 && pending_durations.size() == 0) begin
         $display("morse_key_timing_packetizer test passed");
      end else begin
         $display("morse_key_timing_packetizer test failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl
rtl/mktp_pkg.sv
rtl/mktp_if.sv
rtl/mktp_ram.sv
rtl/mktp_ctrl.sv
rtl/mktp_dp.sv
rtl/morse_key_timing_packetizer.sv
test/tb.sv
